[rtl/ole_pkg.sv]
// ----------------------------------------------------------------------------
// ole_pkg
// shared opcodes, status codes and field widths of the ordered list engine
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int unsigned OpW  = 4;
  localparam int unsigned ValW = 32;
  localparam int unsigned PosW = 6;
  localparam int unsigned StW  = 3;

  typedef enum logic [OpW-1:0] {
    OP_INSERT_AT    = 4'd0,
    OP_INSERT_FIRST = 4'd1,
    OP_INSERT_LAST  = 4'd2,
    OP_SEARCH       = 4'd3,
    OP_REMOVE       = 4'd4,
    OP_COUNT        = 4'd5,
    OP_SUM          = 4'd6,
    OP_REVERSE      = 4'd7,
    OP_FRONT        = 4'd8,
    OP_BACK         = 4'd9,
    OP_MIDDLE       = 4'd10
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // per-cycle command broadcast from the sequencer to every cell
  typedef struct packed {
    logic            shift_up;   // cells at or above lo take the lower neighbor
    logic            shift_dn;   // cells at or above lo take the upper neighbor
    logic            write;      // cell at wr_idx takes wr_data
    logic [ValW-1:0] wr_data;
  } cell_cmd_t;

endpackage

[rtl/ole_if.sv]
// ----------------------------------------------------------------------------
// ole_req_if / ole_rsp_if
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface ole_req_if;
  logic              valid;
  logic              ready;
  logic [3:0]        opcode;
  logic signed [31:0] value;
  logic [5:0]        position;
  modport source (output valid, opcode, value, position, input ready);
  modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface ole_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [2:0]         status;
  logic [5:0]         list_length;
  modport source (output valid, result_value, status, list_length, input ready);
  modport sink   (input valid, result_value, status, list_length, output ready);
endinterface

[rtl/ole_cell.sv]
// ----------------------------------------------------------------------------
// ole_cell
// one list slot; shifts toward either neighbor or takes a direct write
// ----------------------------------------------------------------------------
module ole_cell (
  input  logic                   clk_i,
  input  ole_pkg::cell_cmd_t     cmd_i,
  input  logic                   active_i,
  input  logic                   sel_i,
  input  logic [31:0]            lower_i,
  input  logic [31:0]            upper_i,
  output logic [31:0]            data_o
);
  import ole_pkg::*;

  logic [31:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.write && sel_i) begin
      data_d = cmd_i.wr_data;
    end else if (active_i && cmd_i.shift_up) begin
      data_d = lower_i;
    end else if (active_i && cmd_i.shift_dn) begin
      data_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
endmodule

[rtl/ordered_list_engine.sv]
// ----------------------------------------------------------------------------
// ordered_list_engine
// bounded ordered list of signed 32-bit integers held in a chain of cells
// ----------------------------------------------------------------------------
// One request on req carries opcode, value and position; exactly one
// response on rsp follows with result_value, status and list_length.
// The list lives in a row of CAPACITY cells. Insert and remove move the
// tail by one slot at once (every cell at or above the insert or remove
// point takes its neighbor); search, count, sum and reverse walk the
// list one entry (reverse: one swap) per cycle through a scan index.
// Inserts, reads, flagged and unused opcodes answer straight from idle;
// search and remove scan up to the first match or the last entry, count
// and sum scan the whole list, reverse swaps from both ends inward.
// One request at a time: a request holds the block until its response
// has been taken. The response sits in an output register; while it is
// not taken the block holds it and accepts no new request. Reset empties
// the list (length zero); cell contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  ole_req_if.sink   req,
  ole_rsp_if.source rsp
);
  import ole_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LenW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (LenW > PosW) ? LenW : PosW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RSP  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] idx_q, idx_d;   // scan index / reverse lo
  logic [LenW-1:0] hi_q, hi_d;
  logic [3:0]      op_q, op_d;
  logic [31:0]     val_q, val_d;
  logic [31:0]     acc_q, acc_d;
  logic [31:0]     res_q, res_d;
  logic [2:0]      st_q, st_d;

  logic [31:0] cell_data [CAPACITY];
  cell_cmd_t   cmd;
  logic [LenW-1:0] lo;
  logic [LenW-1:0] wr_idx;
  logic [LenW-1:0] wr_idx2;
  logic            write2;
  logic [31:0]     wr_data2;

  // common-width views of input position and length
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] len_ext;
  assign pos_ext = CmpW'(req.position);
  assign len_ext = CmpW'(len_q);

  logic [31:0] cur_rd, hi_rd;
  assign cur_rd = cell_data[idx_q[IdxW-1:0]];
  assign hi_rd  = cell_data[hi_q[IdxW-1:0]];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [31:0] lower, upper;
    logic        sel;
    if (g == 0) begin : g_lo
      assign lower = 32'd0;
    end else begin : g_lon
      assign lower = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign upper = 32'd0;
    end else begin : g_hin
      assign upper = cell_data[g+1];
    end
    assign sel = (cmd.write && wr_idx == LenW'(g)) || (write2 && wr_idx2 == LenW'(g));
    ole_cell u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cell_cmd_t'{shift_up: cmd.shift_up, shift_dn: cmd.shift_dn,
                             write: cmd.write || write2,
                             wr_data: (write2 && wr_idx2 == LenW'(g)) ? wr_data2
                                                                    : cmd.wr_data}),
      .active_i (LenW'(g) >= lo),
      .sel_i    (sel),
      .lower_i  (lower),
      .upper_i  (upper),
      .data_o   (cell_data[g])
    );
  end

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = (state_q == S_RSP);
  assign rsp.result_value = res_q;
  assign rsp.status = st_q;
  assign rsp.list_length = 6'(len_q);

  always_comb begin
    logic [LenW-1:0] ins_pos;
    logic            ins_bad;
    state_d = state_q;
    len_d = len_q;
    idx_d = idx_q;
    hi_d = hi_q;
    op_d = op_q;
    val_d = val_q;
    acc_d = acc_q;
    res_d = res_q;
    st_d = st_q;
    cmd = '{shift_up: 1'b0, shift_dn: 1'b0, write: 1'b0, wr_data: val_q};
    lo = '0;
    wr_idx = '0;
    wr_idx2 = '0;
    write2 = 1'b0;
    wr_data2 = '0;
    ins_pos = '0;
    ins_bad = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          op_d = req.opcode;
          val_d = req.value;
          idx_d = '0;
          hi_d = len_q - LenW'(1);
          acc_d = '0;
          res_d = '0;
          st_d = ST_OK;
          state_d = S_RSP;
          priority case (req.opcode)
            OP_INSERT_AT, OP_INSERT_FIRST, OP_INSERT_LAST: begin
              if (req.opcode == OP_INSERT_AT) begin
                ins_bad = pos_ext > len_ext;
                ins_pos = LenW'(req.position);
              end else if (req.opcode == OP_INSERT_FIRST) begin
                ins_pos = '0;
              end else begin
                ins_pos = len_q;
              end
              if (ins_bad) begin
                st_d = ST_BAD_POS;
              end else if (len_q == LenW'(CAPACITY)) begin
                st_d = ST_FULL;
              end else begin
                lo = ins_pos;
                cmd.shift_up = 1'b1;
                write2 = 1'b1;
                wr_idx2 = ins_pos;
                wr_data2 = req.value;
                len_d = len_q + LenW'(1);
              end
            end
            OP_SEARCH, OP_REMOVE: begin
              if (len_q == '0) begin
                st_d = ST_EMPTY;
                if (req.opcode == OP_SEARCH) res_d = '1;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_COUNT, OP_SUM, OP_REVERSE: begin
              if (len_q > LenW'(1) || (len_q != '0 && req.opcode != OP_REVERSE)) begin
                state_d = S_SCAN;
              end
            end
            OP_FRONT, OP_BACK, OP_MIDDLE: begin
              if (len_q == '0) begin
                st_d = ST_EMPTY;
              end else if (req.opcode == OP_FRONT) begin
                res_d = cell_data[0];
              end else if (req.opcode == OP_BACK) begin
                res_d = cell_data[hi_d[IdxW-1:0]];
              end else begin
                res_d = cell_data[IdxW'(len_q >> 1)];
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        priority case (op_q)
          OP_SEARCH, OP_REMOVE: begin
            if (cur_rd == val_q) begin
              if (op_q == OP_SEARCH) begin
                res_d = 32'(idx_q);
              end else begin
                lo = idx_q;
                cmd.shift_dn = 1'b1;
                len_d = len_q - LenW'(1);
              end
              state_d = S_RSP;
            end else if (idx_q == len_q - LenW'(1)) begin
              st_d = ST_NOT_FOUND;
              if (op_q == OP_SEARCH) res_d = '1;
              state_d = S_RSP;
            end else begin
              idx_d = idx_q + LenW'(1);
            end
          end
          OP_COUNT, OP_SUM: begin
            if (op_q == OP_SUM) begin
              acc_d = acc_q + cur_rd;
            end else if (cur_rd == val_q) begin
              acc_d = acc_q + 32'd1;
            end
            idx_d = idx_q + LenW'(1);
            if (idx_q == len_q - LenW'(1)) begin
              res_d = acc_d;
              state_d = S_RSP;
            end
          end
          OP_REVERSE: begin
            lo = LenW'(CAPACITY);
            cmd.write = 1'b1;
            cmd.wr_data = hi_rd;
            wr_idx = idx_q;
            write2 = 1'b1;
            wr_idx2 = hi_q;
            wr_data2 = cur_rd;
            idx_d = idx_q + LenW'(1);
            hi_d = hi_q - LenW'(1);
            if (idx_q + LenW'(1) >= hi_q - LenW'(1) || idx_q + LenW'(1) >= hi_q) begin
              state_d = S_RSP;
            end
          end
          default: state_d = S_RSP;
        endcase
      end
      S_RSP: begin
        if (rsp.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q <= '0;
    end else begin
      state_q <= state_d;
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    hi_q <= hi_d;
    op_q <= op_d;
    val_q <= val_d;
    acc_q <= acc_d;
    res_q <= res_d;
    st_q <= st_d;
  end

  // length never exceeds capacity
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(CAPACITY)) else $error("length above capacity");

  // response holds while stalled
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(res_q) && $stable(st_q))
    else $error("response changed while stalled");

  // length only moves by one per request
  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q != $past(len_q) |-> len_q == $past(len_q) + LenW'(1) ||
                              len_q == $past(len_q) - LenW'(1))
    else $error("length jumped");

  // no request taken while a response is pending
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !req.ready) else $error("request accepted during response");
endmodule

[dv/ole_list_checker.sv]
// ----------------------------------------------------------------------------
// ole_list_checker
// watches the request and response channels of the ordered list engine,
// keeps its own copy of the list to work out each response, and compares
// every response field by field in order
// ----------------------------------------------------------------------------
module ole_list_checker
  import ole_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  ole_req_if.sink   req,
  ole_rsp_if.sink   rsp,
  output int        errors_o,
  output int        pending_o
);

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
    logic [5:0]         list_length;
  } list_rsp_t;

  logic [31:0] list_q [CAPACITY];
  int unsigned list_len;
  list_rsp_t   rsp_queue[$];

  assign pending_o = rsp_queue.size();

  function automatic int find_value(logic [31:0] v);
    for (int i = 0; i < list_len; i++) if (list_q[i] == v) return i;
    return -1;
  endfunction

  function automatic status_e put_value(int unsigned pos, logic [31:0] v);
    if (pos > list_len) return ST_BAD_POS;
    if (list_len >= CAPACITY) return ST_FULL;
    for (int i = list_len; i > pos; i--) list_q[i] = list_q[i-1];
    list_q[pos] = v;
    list_len++;
    return ST_OK;
  endfunction

  function automatic list_rsp_t apply_request(logic [3:0] op, logic [31:0] v,
                                              logic [5:0] pos);
    logic [31:0] res;
    status_e     st;
    int          idx;
    logic [31:0] t;
    res = '0;
    st  = ST_OK;
    case (op)
      OP_INSERT_AT:    st = put_value(pos, v);
      OP_INSERT_FIRST: st = put_value(0, v);
      OP_INSERT_LAST:  st = put_value(list_len, v);
      OP_SEARCH: begin
        idx = find_value(v);
        if (list_len == 0) begin
          st = ST_EMPTY; res = '1;
        end else if (idx < 0) begin
          st = ST_NOT_FOUND; res = '1;
        end else begin
          res = idx;
        end
      end
      OP_REMOVE: begin
        idx = find_value(v);
        if (list_len == 0) st = ST_EMPTY;
        else if (idx < 0) st = ST_NOT_FOUND;
        else begin
          for (int i = idx; i + 1 < list_len; i++) list_q[i] = list_q[i+1];
          list_len--;
        end
      end
      OP_COUNT: for (int i = 0; i < list_len; i++) if (list_q[i] == v) res++;
      OP_SUM:   for (int i = 0; i < list_len; i++) res += list_q[i];
      OP_REVERSE: begin
        for (int i = 0; i < list_len / 2; i++) begin
          t = list_q[i];
          list_q[i] = list_q[list_len-1-i];
          list_q[list_len-1-i] = t;
        end
      end
      OP_FRONT, OP_BACK, OP_MIDDLE: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (op == OP_FRONT) res = list_q[0];
        else if (op == OP_BACK) res = list_q[list_len-1];
        else res = list_q[list_len/2];
      end
      default: ;
    endcase
    return '{result_value: res, status: st, list_length: list_len[5:0]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_rsp_t want;
    if (!rst_ni) begin
      list_len = 0;
      errors_o <= 0;
      rsp_queue.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (rsp_queue.size() == 0) begin
          $display("%0t: response with none expected: %0d/%0d/%0d", $time,
                   rsp.result_value, rsp.status, rsp.list_length);
          errors_o <= errors_o + 1;
        end else begin
          want = rsp_queue.pop_front();
          if (want.result_value !== rsp.result_value || want.status !== rsp.status ||
              want.list_length !== rsp.list_length) begin
            $display("%0t: mismatch exp %0d/%0d/%0d got %0d/%0d/%0d", $time,
                     want.result_value, want.status, want.list_length,
                     rsp.result_value, rsp.status, rsp.list_length);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (req.valid && req.ready)
        rsp_queue.push_back(apply_request(req.opcode, req.value, req.position));
    end
  end

endmodule

[dv/ordered_list_engine_test.sv]
// ----------------------------------------------------------------------------
// ordered_list_engine_test
// drives directed and random list operations into the ordered list engine
// with bursty requests and a stalling response side; the checker beside
// the block predicts and compares every response
// ----------------------------------------------------------------------------
module ordered_list_engine_test;
  import ole_pkg::*;

  localparam int unsigned CAPACITY = 32;
  localparam int          MaxCycles = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors;
  int   pending;
  int   cycles = 0;
  int   model_len = 0;
  logic [31:0] recent[$];
  bit   stall_mode = 1'b0;

  ole_req_if req ();
  ole_rsp_if rsp ();

  ordered_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk_i, .rst_ni, .req(req.sink), .rsp(rsp.source)
  );

  ole_list_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk_i, .rst_ni, .req(req.sink), .rsp(rsp.sink),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // response side stall pattern
  always @(posedge clk_i) begin
    if (($urandom % 300) == 0) stall_mode <= ~stall_mode;
    rsp.ready <= stall_mode ? 1'b1 : (($urandom % 4) != 0);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= MaxCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  // length tracking only steers the stimulus mix
  task automatic send_request(logic [3:0] op, logic [31:0] v, logic [5:0] pos);
    req.valid    <= 1'b1;
    req.opcode   <= op;
    req.value    <= v;
    req.position <= pos;
    do @(posedge clk_i); while (!req.ready);
    if (op inside {OP_INSERT_FIRST, OP_INSERT_LAST} && model_len < CAPACITY) model_len++;
    if (op == OP_INSERT_AT && pos <= model_len && model_len < CAPACITY) model_len++;
    if (op <= OP_INSERT_LAST) recent.push_back(v);
    if (recent.size() > 16) void'(recent.pop_front());
    if (op == OP_REMOVE) model_len = checker_i.list_len;
  endtask

  task automatic pause_request(int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return recent.size() ? recent[$urandom_range(0, recent.size() - 1)] : 0;
      default: return $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 9);
    endcase
  endfunction

  initial begin
    int burst;
    logic [3:0] op;
    logic [5:0] pos;
    req.valid = 1'b0;
    req.opcode = '0;
    req.value = '0;
    req.position = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int o = OP_SEARCH; o <= OP_MIDDLE; o++) send_request(4'(o), 32'd5, 6'd0);
    send_request(OP_INSERT_AT, 32'd7, 6'd1);
    send_request(4'd15, 32'hffff_ffff, 6'h3f);
    send_request(OP_INSERT_AT, 32'h8000_0000, 6'd0);
    send_request(OP_INSERT_FIRST, 32'h7fff_ffff, 6'd0);
    send_request(OP_INSERT_LAST, 32'hffff_ffff, 6'd0);
    send_request(OP_INSERT_AT, 32'd3, 6'd1);
    send_request(OP_SEARCH, 32'd99, 6'd0);
    send_request(OP_REMOVE, 32'd99, 6'd0);
    for (int o = OP_SEARCH; o <= OP_MIDDLE; o++) send_request(4'(o), 32'd3, 6'd0);
    send_request(4'd11, 32'd0, 6'd0);
    // fill to capacity then try insert at positions 32 and 33 and one more insert first
    while (model_len < CAPACITY) send_request(OP_INSERT_LAST, $urandom, 6'd0);
    send_request(OP_INSERT_AT, 32'd1, 6'd32);
    send_request(OP_INSERT_AT, 32'd1, 6'd33);
    send_request(OP_INSERT_FIRST, 32'd1, 6'd0);
    send_request(OP_SUM, 32'd0, 6'd0);
    send_request(OP_REVERSE, 32'd0, 6'd0);
    send_request(OP_MIDDLE, 32'd0, 6'd0);
    pause_request(0);
    while (pending != 0) @(posedge clk_i);
    for (int n = 0; n < 1400; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++, n++) begin
        if ($urandom_range(0, 99) < 3) op = 4'($urandom_range(11, 15));
        else if (model_len < 6) op = 4'($urandom_range(0, 4) < 3 ? $urandom_range(0, 2)
                                                                 : $urandom_range(3, 10));
        else if (model_len > 28) op = $urandom_range(0, 2) == 0 ? OP_REMOVE
                                                                : 4'($urandom_range(0, 10));
        else op = 4'($urandom_range(0, 10));
        pos = 6'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, model_len));
        send_request(op, pick_value(), pos);
      end
      if ($urandom_range(0, 1)) pause_request($urandom_range(1, 40));
      if ($urandom_range(0, 60) == 0) begin
        req.valid <= 1'b0;
        while (pending != 0) @(posedge clk_i);
      end
    end
    req.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
